### sv/icsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icsb_pkg
// Shared types and codes for the indexed character sequence buffer: command
// and response layouts, opcodes, status codes and the default capacity.
// ----------------------------------------------------------------------------
package icsb_pkg;

  // field widths fixed by the command and response layout
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  // default number of entries the store holds
  localparam int DEFAULT_CAPACITY = 64;

  // command opcodes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT_AT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_AT  = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_AT    = 3'd6;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // one command transaction
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] letter;
  } cmd_t;

  // one response transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;
    logic [CHAR_W-1:0]   read_letter;
  } rsp_t;

endpackage

### sv/icsb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icsb_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module icsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/indexed_char_sequence_buffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_char_sequence_buffer_unit
// Bounded ordered store of byte characters with insert, remove and read
// commands at the front, the back or a position.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one response
// follows, shown on rsp for the single cycle in which done is high, and the
// receiver has to take it then. A failed command changes nothing. The entries
// sit in one RAM with one write and one registered read port, so inserts and
// removes move the entries behind the position one per cycle. Every accepted
// command is decoded first; a failed command, the unused opcode or a remove
// that moves nothing is answered from the decode, a read from a read state,
// and an insert that moves nothing from the put state. A command that moves
// entries reads and writes them back one place over, drains the last
// write-back and, for an insert, then puts the new letter. busy drops in the
// cycle done is shown, so the next command can be taken there.
// ----------------------------------------------------------------------------
module indexed_char_sequence_buffer_unit #(
  parameter int CAPACITY = icsb_pkg::DEFAULT_CAPACITY
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  icsb_pkg::cmd_t cmd,
  output logic           done,
  output icsb_pkg::rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > icsb_pkg::POS_W) ? CW : icsb_pkg::POS_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;

  logic [2:0]  state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] cursor, cursor_next;
  logic [AW-1:0] last, last_next;
  logic [AW-1:0] tgt, tgt_next;
  logic          dir_up, dir_up_next;
  logic          wpend, wpend_next;
  logic [AW-1:0] wpend_addr, wpend_addr_next;
  logic          done_next;
  icsb_pkg::rsp_t rsp_next;

  // latched command
  logic [icsb_pkg::OP_W-1:0]   op_r;
  logic [PW-1:0]               pos_r;
  logic [icsb_pkg::CHAR_W-1:0] letter_r;

  // ram ports
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [icsb_pkg::CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [icsb_pkg::CHAR_W-1:0] ram_rdata;

  // decode helpers
  logic          full, empty;
  logic [PW-1:0] cnt_w;
  logic [AW-1:0] cnt_m1;
  logic [CW-1:0] ins_pos;
  logic [AW-1:0] rem_pos;

  icsb_ram #(
    .WIDTH (icsb_pkg::CHAR_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy  = (state != S_IDLE);
  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);
  assign cnt_w = PW'(count);
  assign cnt_m1 = AW'(count - CW'(1));

  // insert and remove positions per opcode
  always_comb begin
    unique case (op_r)
      icsb_pkg::OP_PUSH_FRONT: ins_pos = '0;
      icsb_pkg::OP_INSERT_AT:  ins_pos = (pos_r >= cnt_w) ? count : CW'(pos_r);
      default:                 ins_pos = count;
    endcase
    unique case (op_r)
      icsb_pkg::OP_POP_FRONT: rem_pos = '0;
      icsb_pkg::OP_POP_BACK:  rem_pos = cnt_m1;
      default:                rem_pos = AW'(pos_r);
    endcase
  end

  // sequencer and shift engine
  always_comb begin
    state_next      = state;
    count_next      = count;
    cursor_next     = cursor;
    last_next       = last;
    tgt_next        = tgt;
    dir_up_next     = dir_up;
    wpend_next      = 1'b0;
    wpend_addr_next = wpend_addr;
    done_next       = 1'b0;
    rsp_next        = rsp;

    // a read issued last cycle is written back one place over
    ram_we    = wpend;
    ram_waddr = wpend_addr;
    ram_wdata = ram_rdata;
    ram_raddr = cursor;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        rsp_next.read_letter = '0;
        rsp_next.length      = icsb_pkg::LEN_W'(count);
        unique case (op_r)
          icsb_pkg::OP_PUSH_FRONT, icsb_pkg::OP_PUSH_BACK,
          icsb_pkg::OP_INSERT_AT: begin
            tgt_next = AW'(ins_pos);
            if (full) begin
              rsp_next.status = icsb_pkg::ST_FULL;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end else if (ins_pos == count) begin
              state_next = S_PUT;
            end else begin
              cursor_next = cnt_m1;
              last_next   = AW'(ins_pos);
              dir_up_next = 1'b1;
              state_next  = S_SHIFT;
            end
          end

          icsb_pkg::OP_POP_FRONT, icsb_pkg::OP_POP_BACK,
          icsb_pkg::OP_REMOVE_AT: begin
            if (empty) begin
              rsp_next.status = icsb_pkg::ST_EMPTY;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end else if (op_r == icsb_pkg::OP_REMOVE_AT && pos_r >= cnt_w) begin
              rsp_next.status = icsb_pkg::ST_RANGE;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end else if (rem_pos == cnt_m1) begin
              count_next      = count - CW'(1);
              rsp_next.status = icsb_pkg::ST_OK;
              rsp_next.length = icsb_pkg::LEN_W'(count - CW'(1));
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end else begin
              cursor_next = rem_pos + AW'(1);
              last_next   = cnt_m1;
              dir_up_next = 1'b0;
              state_next  = S_SHIFT;
            end
          end

          icsb_pkg::OP_READ_AT: begin
            if (empty) begin
              rsp_next.status = icsb_pkg::ST_EMPTY;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end else if (pos_r >= cnt_w) begin
              rsp_next.status = icsb_pkg::ST_RANGE;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end else begin
              ram_raddr  = AW'(pos_r);
              state_next = S_READ;
            end
          end

          default: begin
            rsp_next.status = icsb_pkg::ST_OK;
            done_next       = 1'b1;
            state_next      = S_IDLE;
          end
        endcase
      end

      // read one entry per cycle, write it back one place over next cycle
      S_SHIFT: begin
        ram_raddr       = cursor;
        wpend_next      = 1'b1;
        wpend_addr_next = dir_up ? (cursor + AW'(1)) : (cursor - AW'(1));
        if (cursor == last) begin
          state_next = S_DRAIN;
        end else begin
          cursor_next = dir_up ? (cursor - AW'(1)) : (cursor + AW'(1));
        end
      end

      // last pending write-back goes out this cycle
      S_DRAIN: begin
        if (dir_up) begin
          state_next = S_PUT;
        end else begin
          count_next      = count - CW'(1);
          rsp_next.status = icsb_pkg::ST_OK;
          rsp_next.length = icsb_pkg::LEN_W'(count - CW'(1));
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end
      end

      // place the new letter in the opened slot
      S_PUT: begin
        ram_we          = 1'b1;
        ram_waddr       = tgt;
        ram_wdata       = letter_r;
        count_next      = count + CW'(1);
        rsp_next.status = icsb_pkg::ST_OK;
        rsp_next.length = icsb_pkg::LEN_W'(count + CW'(1));
        done_next       = 1'b1;
        state_next      = S_IDLE;
      end

      S_READ: begin
        rsp_next.status      = icsb_pkg::ST_OK;
        rsp_next.read_letter = ram_rdata;
        done_next            = 1'b1;
        state_next           = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      wpend <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      wpend <= wpend_next;
      done  <= done_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cursor     <= cursor_next;
    last       <= last_next;
    tgt        <= tgt_next;
    dir_up     <= dir_up_next;
    wpend_addr <= wpend_addr_next;
    rsp        <= rsp_next;
    if (state == S_IDLE && start) begin
      op_r     <= cmd.opcode;
      pos_r    <= PW'(cmd.position);
      letter_r <= cmd.letter;
    end
  end

`ifndef ASSERT_OFF
  // fill level stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // an accepted transaction is decoded next and never answered at once
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_DECODE && !done))
    else $error("accepted transaction not decoded");

  // fill level only moves together with a response
  a_count_with_done: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && count != $past(count)) |-> done)
    else $error("entry count changed without response");

  // shift write-back never hits the entry being read
  a_shift_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && ram_we) |-> (ram_waddr != ram_raddr))
    else $error("shift read and write at same entry");
`endif

endmodule
